@@ rtl/rat_pkg.sv @@
// Shared types and constants of the row activation tracker.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rat_pkg;

  localparam int CNT_W = 24;
  localparam int CYC_W = 32;
  localparam int FROW_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] THRESHOLD_RST = 24'd12500;
  localparam logic [6:0] TRACKED_RST = 7'd64;
  localparam logic [CYC_W-1:0] WINDOW_RST = 32'd85333333;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VICTIM = 2'd3;

  typedef struct packed {
    logic [FROW_W-1:0] act_row;
    logic [CYC_W-1:0] act_cycle;
  } act_t;

  typedef struct packed {
    logic [FROW_W-1:0] refresh_row;
    logic [CYC_W-1:0] refresh_cycle;
    logic last_of_run;
  } refr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE,
    ST_CHECK,
    ST_NEXT,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    STEP_SELF,
    STEP_LO,
    STEP_HI
  } step_t;

  typedef enum logic {
    OP_COUNT,
    OP_ZERO
  } op_t;

  // table control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic set_valid;
    logic clr_all;
  } tbl_ctl_t;

endpackage

@@ rtl/rat_table.sv @@
// Row/count table: one write port, one registered read port, valid flops.
// Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_table #(
  parameter int ENTRIES = 64,
  parameter int ROW_BITS = 16,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic clk,
  input  logic rst,
  input  rat_pkg::tbl_ctl_t ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ROW_BITS-1:0] wr_row,
  input  logic [rat_pkg::CNT_W-1:0] wr_cnt,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ROW_BITS-1:0] rd_row,
  output logic [rat_pkg::CNT_W-1:0] rd_cnt,
  output logic rd_valid
);

  logic [ROW_BITS-1:0] mem_row [ENTRIES];
  logic [rat_pkg::CNT_W-1:0] mem_cnt [ENTRIES];
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_row[wr_addr] <= wr_row;
      mem_cnt[wr_addr] <= wr_cnt;
    end
    rd_row <= mem_row[rd_addr];
    rd_cnt <= mem_cnt[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      // a clear may re-enter one entry in the same cycle
      if (ctl.clr_all) begin
        valid <= ctl.set_valid ? (ENTRIES'(1) << wr_addr) : '0;
      end else if (ctl.set_valid) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

@@ rtl/rat_rem.sv @@
// Bit-serial remainder unit, one dividend bit per cycle (32 steps).
// Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_rem (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rat_pkg::CYC_W-1:0] dividend,
  input  logic [rat_pkg::CYC_W-1:0] divisor,
  output logic done,
  output logic [rat_pkg::CYC_W-1:0] rem
);

  logic [rat_pkg::CYC_W-1:0] dd;
  logic [rat_pkg::CYC_W-1:0] dv;
  logic [5:0] steps;
  logic busy;
  logic [rat_pkg::CYC_W:0] trial;

  assign trial = {rem, dd[rat_pkg::CYC_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= '0;
        dd <= dividend;
        dv <= divisor;
        rem <= '0;
      end else if (busy) begin
        dd <= dd << 1;
        if (trial >= {1'b0, dv}) begin
          rem <= rat_pkg::CYC_W'(trial - {1'b0, dv});
        end else begin
          rem <= trial[rat_pkg::CYC_W-1:0];
        end
        steps <= steps + 6'd1;
        if (steps == 6'(rat_pkg::CYC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/rowhammer_activation_tracker_core.sv @@
// Rowhammer activation tracker: Misra-Gries table with spillover counter.
// A table update scans all ENTRIES entries; aggressor mode takes one scan,
// victim mode up to three.
// A new window runs the 32-step remainder unit instead of a scan.
// One word at a time: input stalls until the word's refresh words have drained.
// Reset (rst, synchronous): table empty, spillover and window start zero.
`timescale 1ns / 1ps

module rowhammer_activation_tracker_core #(
  parameter int ENTRIES = 64,
  parameter int ROW_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rat_pkg::CFG_W-1:0] cfg_data,
  input  logic act_valid,
  output logic act_stall,
  input  rat_pkg::act_t act_word,
  output logic ref_valid,
  input  logic ref_stall,
  output rat_pkg::refr_t ref_word
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SC_W = IDX_W + 1;
  localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};
  localparam logic [SC_W-1:0] SCAN_END = SC_W'(ENTRIES);

  // configuration
  logic [rat_pkg::CNT_W-1:0] threshold;
  logic [6:0] tracked_rows;
  logic [rat_pkg::CYC_W-1:0] window_cycles;
  logic victim_mode;

  // block state
  logic [rat_pkg::CNT_W-1:0] spill;
  logic [rat_pkg::CYC_W-1:0] window_start;

  // sequencer
  rat_pkg::state_t state, state_next;
  rat_pkg::step_t step;
  rat_pkg::op_t op;
  logic [ROW_BITS-1:0] row_q;
  logic [rat_pkg::CYC_W-1:0] cyc_q;
  logic [ROW_BITS-1:0] cur;
  logic [rat_pkg::CNT_W-1:0] cur_cnt;
  logic cur_in;
  logic [IDX_W-1:0] cur_idx;

  // scan pipeline and accumulators
  logic [SC_W-1:0] scan_cnt;
  logic p_v;
  logic [IDX_W-1:0] p_idx;
  logic hit, free_found, best_found;
  logic [IDX_W-1:0] hit_idx, free_idx, best_idx;
  logic [rat_pkg::CNT_W-1:0] hit_cnt, best_cnt;
  logic [ROW_BITS-1:0] best_row;
  logic [SC_W-1:0] occ;

  // result slots
  logic [ROW_BITS-1:0] res_row [2];
  logic [rat_pkg::CYC_W-1:0] res_cyc [2];
  logic [1:0] res_n;
  logic drain_idx;

  // table port
  rat_pkg::tbl_ctl_t tctl;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [rat_pkg::CNT_W-1:0] wr_cnt;
  logic [ROW_BITS-1:0] rd_row;
  logic [rat_pkg::CNT_W-1:0] rd_cnt;
  logic rd_valid;

  // remainder unit
  logic rem_start, rem_done;
  logic [rat_pkg::CYC_W-1:0] rem;

  logic accept, win_hit, scan_issue, scan_done, room, over, out_load, last_slot;
  logic [rat_pkg::CNT_W-1:0] spill_inc, hit_inc;
  logic [ROW_BITS-1:0] act_row_m;

  assign act_row_m = ROW_BITS'(act_word.act_row);
  assign accept = act_valid && !act_stall;
  assign act_stall = (state != rat_pkg::ST_IDLE);
  assign win_hit = (window_start + window_cycles) <= act_word.act_cycle;

  assign spill_inc = (spill == rat_pkg::CNT_MAX) ? spill : spill + 1'b1;
  assign hit_inc = (hit_cnt == rat_pkg::CNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
  assign room = (32'(occ) < 32'(tracked_rows)) && (32'(occ) < 32'(ENTRIES));
  assign over = cur_cnt >= threshold;

  assign scan_issue = (state == rat_pkg::ST_SCAN) && (scan_cnt != SCAN_END);
  assign scan_done = (scan_cnt == SCAN_END) && !p_v;
  assign rd_addr = scan_cnt[IDX_W-1:0];

  assign out_load = (state == rat_pkg::ST_DRAIN) && (res_n != 2'd0) &&
                    (!ref_valid || !ref_stall);
  assign last_slot = ({1'b0, drain_idx} + 2'd1) == res_n;

  rat_table #(.ENTRIES(ENTRIES), .ROW_BITS(ROW_BITS)) u_table (
    .clk(clk), .rst(rst), .ctl(tctl), .wr_addr(wr_addr), .wr_row(cur),
    .wr_cnt(wr_cnt), .rd_addr(rd_addr), .rd_row(rd_row), .rd_cnt(rd_cnt),
    .rd_valid(rd_valid)
  );

  rat_rem u_rem (
    .clk(clk), .rst(rst), .start(rem_start), .dividend(cyc_q),
    .divisor(window_cycles), .done(rem_done), .rem(rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rat_pkg::THRESHOLD_RST;
      tracked_rows <= rat_pkg::TRACKED_RST;
      window_cycles <= rat_pkg::WINDOW_RST;
      victim_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rat_pkg::CFG_THRESHOLD: threshold <= cfg_data[rat_pkg::CNT_W-1:0];
        rat_pkg::CFG_TRACKED:   tracked_rows <= cfg_data[6:0];
        rat_pkg::CFG_WINDOW:    window_cycles <= cfg_data;
        rat_pkg::CFG_VICTIM:    victim_mode <= cfg_data[0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rat_pkg::ST_IDLE:
        if (accept) begin
          state_next = win_hit ? rat_pkg::ST_WIN : rat_pkg::ST_SCAN;
        end
      rat_pkg::ST_WIN: state_next = rat_pkg::ST_DIV;
      rat_pkg::ST_DIV:
        if (rem_done) begin
          state_next = rat_pkg::ST_IDLE;
        end
      rat_pkg::ST_SCAN:
        if (scan_done) begin
          state_next = rat_pkg::ST_UPDATE;
        end
      rat_pkg::ST_UPDATE:
        state_next = (op == rat_pkg::OP_ZERO) ? rat_pkg::ST_NEXT : rat_pkg::ST_CHECK;
      rat_pkg::ST_CHECK:
        state_next = victim_mode ? rat_pkg::ST_NEXT : rat_pkg::ST_DRAIN;
      rat_pkg::ST_NEXT:
        unique case (step)
          rat_pkg::STEP_SELF:
            if (row_q != '0) begin
              state_next = rat_pkg::ST_SCAN;
            end
          rat_pkg::STEP_LO:
            if (row_q != ROW_MAX) begin
              state_next = rat_pkg::ST_SCAN;
            end
          default: state_next = rat_pkg::ST_DRAIN;
        endcase
      rat_pkg::ST_DRAIN:
        if (res_n == 2'd0 || (out_load && last_slot)) begin
          state_next = rat_pkg::ST_IDLE;
        end
      default: state_next = rat_pkg::ST_IDLE;
    endcase
  end

  // table and remainder unit controls
  always_comb begin
    tctl = '0;
    wr_addr = '0;
    wr_cnt = '0;
    rem_start = 1'b0;
    unique case (state)
      rat_pkg::ST_WIN: begin
        rem_start = 1'b1;
        tctl.clr_all = 1'b1;
        if (tracked_rows != '0) begin
          tctl.wr_en = 1'b1;
          tctl.set_valid = 1'b1;
          wr_cnt = rat_pkg::CNT_W'(1);
        end
      end
      rat_pkg::ST_UPDATE:
        if (op == rat_pkg::OP_ZERO) begin
          tctl.wr_en = hit;
          wr_addr = hit_idx;
        end else if (hit) begin
          tctl.wr_en = 1'b1;
          wr_addr = hit_idx;
          wr_cnt = hit_inc;
        end else if (room) begin
          tctl.wr_en = 1'b1;
          tctl.set_valid = 1'b1;
          wr_addr = free_idx;
          wr_cnt = rat_pkg::CNT_W'(1);
        end else if (best_found) begin
          tctl.wr_en = 1'b1;
          wr_addr = best_idx;
          wr_cnt = spill_inc;
        end
      rat_pkg::ST_CHECK: begin
        tctl.wr_en = over && cur_in;
        wr_addr = cur_idx;
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rat_pkg::ST_IDLE;
      spill <= '0;
      window_start <= '0;
      res_n <= '0;
      drain_idx <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        rat_pkg::ST_IDLE:
          if (accept) begin
            row_q <= act_row_m;
            cyc_q <= act_word.act_cycle;
            cur <= act_row_m;
            res_n <= '0;
            drain_idx <= 1'b0;
            step <= rat_pkg::STEP_SELF;
            op <= victim_mode ? rat_pkg::OP_ZERO : rat_pkg::OP_COUNT;
            scan_cnt <= '0;
            p_v <= 1'b0;
            hit <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            occ <= '0;
          end
        rat_pkg::ST_WIN: spill <= '0;
        rat_pkg::ST_DIV:
          if (rem_done) begin
            window_start <= (window_cycles == '0) ? cyc_q : cyc_q - rem;
          end
        rat_pkg::ST_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          p_v <= scan_issue;
          p_idx <= rd_addr;
          if (p_v && rd_valid) begin
            occ <= occ + 1'b1;
            if (!hit && rd_row == cur) begin
              hit <= 1'b1;
              hit_idx <= p_idx;
              hit_cnt <= rd_cnt;
            end
            // eviction candidate: lowest count under the raised spillover
            if (rd_cnt < spill_inc && (!best_found || rd_cnt < best_cnt ||
                (rd_cnt == best_cnt && rd_row < best_row))) begin
              best_found <= 1'b1;
              best_idx <= p_idx;
              best_cnt <= rd_cnt;
              best_row <= rd_row;
            end
          end
          if (p_v && !rd_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx <= p_idx;
          end
        end
        rat_pkg::ST_UPDATE:
          if (op == rat_pkg::OP_COUNT) begin
            if (hit) begin
              cur_cnt <= hit_inc;
              cur_in <= 1'b1;
              cur_idx <= hit_idx;
            end else if (room) begin
              cur_cnt <= rat_pkg::CNT_W'(1);
              cur_in <= 1'b1;
              cur_idx <= free_idx;
            end else if (best_found) begin
              spill <= best_cnt;
              cur_cnt <= spill_inc;
              cur_in <= 1'b1;
              cur_idx <= best_idx;
            end else begin
              spill <= spill_inc;
              cur_cnt <= '0;
              cur_in <= 1'b0;
            end
          end
        rat_pkg::ST_CHECK:
          if (over) begin
            if (victim_mode) begin
              res_row[res_n[0]] <= cur;
              res_cyc[res_n[0]] <= cyc_q + 1'b1;
              res_n <= res_n + 2'd1;
            end else if (row_q != '0) begin
              res_row[0] <= row_q - 1'b1;
              res_cyc[0] <= cyc_q + 1'b1;
              if (row_q != ROW_MAX) begin
                res_row[1] <= row_q + 1'b1;
                res_cyc[1] <= cyc_q + 2'd2;
                res_n <= 2'd2;
              end else begin
                res_n <= 2'd1;
              end
            end else begin
              // row zero has no lower neighbor
              res_row[0] <= row_q + 1'b1;
              res_cyc[0] <= cyc_q + 2'd2;
              res_n <= 2'd1;
            end
          end
        rat_pkg::ST_NEXT: begin
          op <= rat_pkg::OP_COUNT;
          scan_cnt <= '0;
          p_v <= 1'b0;
          hit <= 1'b0;
          free_found <= 1'b0;
          best_found <= 1'b0;
          occ <= '0;
          unique case (step)
            rat_pkg::STEP_SELF: begin
              step <= rat_pkg::STEP_LO;
              cur <= row_q - 1'b1;
            end
            rat_pkg::STEP_LO: begin
              step <= rat_pkg::STEP_HI;
              cur <= row_q + 1'b1;
            end
            default: ;
          endcase
        end
        rat_pkg::ST_DRAIN:
          if (out_load) begin
            drain_idx <= ~drain_idx;
          end
        default: ;
      endcase
    end
  end

  // output register, parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid <= 1'b0;
    end else if (out_load) begin
      ref_valid <= 1'b1;
    end else if (!ref_stall) begin
      ref_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ref_word.refresh_row <= rat_pkg::FROW_W'(res_row[drain_idx]);
      ref_word.refresh_cycle <= res_cyc[drain_idx];
      ref_word.last_of_run <= last_slot;
    end
  end

endmodule

@@ rtl/rat_chk.sv @@
// Port-level checks of the activation tracker, bound to the top level.
// Depends on rat_pkg and rowhammer_activation_tracker_core.
`timescale 1ns / 1ps

module rat_chk (
  input logic clk,
  input logic rst,
  input logic act_valid,
  input logic act_stall,
  input logic ref_valid,
  input logic ref_stall,
  input rat_pkg::refr_t ref_word
);

  // one word in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (act_valid && !act_stall) |=> act_stall)
    else $error("input taken while a word is in flight");

  // a run continues until its last word
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (ref_valid && !ref_stall && !ref_word.last_of_run) |=> ref_valid)
    else $error("refresh run broken before its last word");

  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    (ref_valid && !ref_word.last_of_run) |-> act_stall)
    else $error("input open while a refresh run is unfinished");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ref_valid && ref_stall) |=> (ref_valid && $stable(ref_word)))
    else $error("stalled refresh word changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !ref_valid)
    else $error("refresh valid after reset");

endmodule

bind rowhammer_activation_tracker_core rat_chk u_rat_chk (.*);

@@ tb/sv/tb_rowhammer_activation_tracker_core.sv @@
// Self-checking bench for the rowhammer activation tracker core.
// Depends on rat_pkg and rowhammer_activation_tracker_core; predicts refreshes in-line.
`timescale 1ns / 1ps

module tb_rowhammer_activation_tracker_core;

  localparam int ENTRIES = 64;
  localparam int ROW_MAX = 65535;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 4 * (ENTRIES + 3) + 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rat_pkg::CFG_IDX_W-1:0] cfg_index = rat_pkg::CFG_THRESHOLD;
  logic [rat_pkg::CFG_W-1:0] cfg_data = '0;
  logic act_valid = 1'b0;
  logic act_stall;
  rat_pkg::act_t act_word = '0;
  logic ref_valid;
  logic ref_stall = 1'b0;
  rat_pkg::refr_t ref_word;

  rowhammer_activation_tracker_core #(.ENTRIES(ENTRIES), .ROW_BITS(16)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .act_valid(act_valid), .act_stall(act_stall), .act_word(act_word),
    .ref_valid(ref_valid), .ref_stall(ref_stall), .ref_word(ref_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: tracked table, spillover, window origin and registers
  logic [15:0] tab_row [ENTRIES];
  logic [23:0] tab_cnt [ENTRIES];
  logic tab_vld [ENTRIES];
  logic [23:0] spill;
  logic [31:0] win_start;
  logic [23:0] thr;
  logic [6:0] tracked;
  logic [31:0] win_len;
  logic victim;

  rat_pkg::act_t act_q[$];          // activations waiting for the driver
  rat_pkg::refr_t refresh_q[$];     // predicted refresh words
  int errors = 0;
  int idle_cycles = 0;
  int act_gap = 0;
  int ref_gap = 0;
  logic [31:0] cyc_now = 0;

  task automatic report(input string what, input rat_pkg::refr_t got,
                        input rat_pkg::refr_t want);
    $display("MISMATCH %s: got row %0d cyc %0d last %0b, want row %0d cyc %0d last %0b",
             what, got.refresh_row, got.refresh_cycle, got.last_of_run,
             want.refresh_row, want.refresh_cycle, want.last_of_run);
    errors++;
  endtask

  function automatic int find_row(input logic [15:0] r);
    for (int i = 0; i < ENTRIES; i++) if (tab_vld[i] && tab_row[i] == r) return i;
    return -1;
  endfunction

  function automatic logic [23:0] count_of(input logic [15:0] r);
    int i;
    i = find_row(r);
    return (i < 0) ? 24'd0 : tab_cnt[i];
  endfunction

  function automatic void clear_row(input logic [15:0] r);
    int i;
    i = find_row(r);
    if (i >= 0) tab_cnt[i] = '0;
  endfunction

  // Misra-Gries update: hit, insert into free slot, or spill and maybe evict
  function automatic void bump_row(input logic [15:0] r);
    int i, best, occ, cap;
    logic [23:0] old;
    best = -1;
    occ = 0;
    i = find_row(r);
    if (i >= 0) begin
      if (tab_cnt[i] != rat_pkg::CNT_MAX) tab_cnt[i]++;
      return;
    end
    cap = (tracked < ENTRIES) ? tracked : ENTRIES;
    for (int k = 0; k < ENTRIES; k++) if (tab_vld[k]) occ++;
    if (occ < cap) begin
      for (int k = 0; k < ENTRIES; k++) if (!tab_vld[k]) begin
        tab_vld[k] = 1'b1; tab_row[k] = r; tab_cnt[k] = 24'd1;
        return;
      end
      return;
    end
    if (spill != rat_pkg::CNT_MAX) spill++;
    for (int k = 0; k < ENTRIES; k++) begin
      if (!tab_vld[k] || tab_cnt[k] >= spill) continue;
      if (best < 0 || tab_cnt[k] < tab_cnt[best] ||
          (tab_cnt[k] == tab_cnt[best] && tab_row[k] < tab_row[best])) best = k;
    end
    if (best >= 0) begin
      old = tab_cnt[best];
      tab_row[best] = r;
      tab_cnt[best] = spill;
      spill = old;
    end
  endfunction

  function automatic void push_refresh(input logic [15:0] r, input logic [31:0] c);
    rat_pkg::refr_t w;
    w.refresh_row = r;
    w.refresh_cycle = c;
    w.last_of_run = 1'b0;
    refresh_q.push_back(w);
  endfunction

  function automatic void predict_activation(input rat_pkg::act_t a);
    logic [15:0] r;
    logic [31:0] c;
    int n0;
    logic [15:0] v;
    r = a.act_row;
    c = a.act_cycle;
    n0 = refresh_q.size();
    if (32'(win_start + win_len) <= c) begin
      for (int k = 0; k < ENTRIES; k++) tab_vld[k] = 1'b0;
      spill = '0;
      if (tracked >= 1) begin
        tab_vld[0] = 1'b1; tab_row[0] = r; tab_cnt[0] = 24'd1;
      end
      win_start = (win_len != 0) ? (c / win_len) * win_len : c;
      return;
    end
    if (!victim) begin
      bump_row(r);
      if (count_of(r) >= thr) begin
        if (r > 0) push_refresh(r - 16'd1, c + 32'd1);
        if (r < ROW_MAX) push_refresh(r + 16'd1, c + 32'd2);
        clear_row(r);
      end
    end else begin
      clear_row(r);
      for (int s = 0; s < 2; s++) begin
        if (s == 0 && r == 0) continue;
        if (s == 1 && r == ROW_MAX) continue;
        v = (s == 0) ? r - 16'd1 : r + 16'd1;
        bump_row(v);
        if (count_of(v) >= thr) begin
          push_refresh(v, c + 32'd1);
          clear_row(v);
        end
      end
    end
    if (refresh_q.size() > n0) refresh_q[refresh_q.size() - 1].last_of_run = 1'b1;
  endfunction

  // driver: word held until accepted, then a random gap before the next one
  always @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (act_valid && !act_stall) begin
      predict_activation(act_word);
      act_gap = $urandom_range(0, 5);
      if (act_gap == 0 && act_q.size() > 0) begin
        act_word <= act_q.pop_front();
      end else begin
        act_valid <= 1'b0;
      end
    end else if (!act_valid && act_q.size() > 0) begin
      if (act_gap > 0) begin
        act_gap--;
      end else begin
        act_word <= act_q.pop_front();
        act_valid <= 1'b1;
      end
    end
  end

  // monitor: compares each refresh word, redraws the stall per word
  always @(posedge clk) begin
    if (!rst) begin
      if (ref_valid && !ref_stall) begin
        if (refresh_q.size() == 0) begin
          report("unexpected word", ref_word, '0);
        end else begin
          if (ref_word.refresh_row != refresh_q[0].refresh_row)
            report("refresh_row", ref_word, refresh_q[0]);
          if (ref_word.refresh_cycle != refresh_q[0].refresh_cycle)
            report("refresh_cycle", ref_word, refresh_q[0]);
          if (ref_word.last_of_run != refresh_q[0].last_of_run)
            report("last_of_run", ref_word, refresh_q[0]);
          void'(refresh_q.pop_front());
        end
        ref_gap = $urandom_range(0, 5);
        ref_stall <= (ref_gap != 0);
      end else if (ref_gap > 0) begin
        ref_gap--;
        ref_stall <= (ref_gap != 0);
      end
    end
  end

  // watchdog on cycles with no accepted word in either direction
  always @(posedge clk) begin
    if (rst || (act_valid && !act_stall) || (ref_valid && !ref_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [rat_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rat_pkg::CFG_THRESHOLD: thr = val[23:0];
      rat_pkg::CFG_TRACKED:   tracked = val[6:0];
      rat_pkg::CFG_WINDOW:    win_len = val;
      rat_pkg::CFG_VICTIM:    victim = val[0];
      default: ;
    endcase
  endtask

  task automatic add_act(input logic [15:0] r, input int unsigned step);
    rat_pkg::act_t a;
    cyc_now = cyc_now + step;
    a.act_row = r;
    a.act_cycle = cyc_now;
    act_q.push_back(a);
  endtask

  // wait for the queue to drain, every refresh to arrive, then the tail latency
  task automatic quiesce();
    wait (act_q.size() == 0 && !act_valid && refresh_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one phase: mostly a small hot set of rows, plus random, edge and complement rows
  task automatic random_phase(input int n, input int hot_span);
    logic [15:0] base;
    int pick;
    base = 16'($urandom_range(1, ROW_MAX - 40));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) add_act(16'(base + $urandom_range(0, hot_span)), $urandom_range(0, 40));
      else if (pick < 8) add_act(16'($urandom), $urandom_range(0, 3));
      else if (pick < 9) add_act(($urandom_range(0, 1) != 0) ? 16'd0 : 16'hFFFF, 1);
      else add_act(16'(~base), $urandom_range(0, 100));
    end
  endtask

  initial begin
    for (int k = 0; k < ENTRIES; k++) begin
      tab_vld[k] = 1'b0; tab_row[k] = '0; tab_cnt[k] = '0;
    end
    spill = '0;
    win_start = '0;
    thr = rat_pkg::THRESHOLD_RST;
    tracked = rat_pkg::TRACKED_RST;
    win_len = rat_pkg::WINDOW_RST;
    victim = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: low threshold aggressor, edge rows, tie eviction, window roll
    write_reg(rat_pkg::CFG_THRESHOLD, 32'd2);
    write_reg(rat_pkg::CFG_TRACKED, 32'd2);
    write_reg(rat_pkg::CFG_WINDOW, 32'd1000);
    add_act(16'd0, 1); add_act(16'd0, 1);             // low edge: only row+1
    add_act(16'hFFFF, 1); add_act(16'hFFFF, 1);       // high edge: only row-1
    add_act(16'd100, 1); add_act(16'd200, 1);         // table full: evict the zeroed edge rows
    add_act(16'd300, 1); add_act(16'd400, 1);         // spill and evict
    add_act(16'd100, 1); add_act(16'd100, 1);
    add_act(16'd5, 2000);                              // window elapsed
    add_act(16'd5, 1);
    quiesce();
    write_reg(rat_pkg::CFG_VICTIM, 32'd1);
    write_reg(rat_pkg::CFG_THRESHOLD, 32'd1);
    add_act(16'd0, 1); add_act(16'hFFFF, 1); add_act(16'd7, 1); add_act(16'd8, 1);
    quiesce();
    write_reg(rat_pkg::CFG_THRESHOLD, 32'd0);          // every check refreshes
    write_reg(rat_pkg::CFG_TRACKED, 32'd0);            // spillover only
    add_act(16'd50, 1); add_act(16'd51, 1); add_act(16'd52, 1);
    quiesce();
    write_reg(rat_pkg::CFG_WINDOW, 32'd0);             // zero window
    write_reg(rat_pkg::CFG_TRACKED, 32'd127);
    add_act(16'd9, 1); add_act(16'd9, 1);
    quiesce();

    // random phases across register settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(rat_pkg::CFG_VICTIM, ph % 2);
      write_reg(rat_pkg::CFG_TRACKED, (ph == 3) ? 32'd64 : $urandom_range(1, 8));
      write_reg(rat_pkg::CFG_THRESHOLD, (ph == 9) ? 32'hFFFFFF : $urandom_range(1, 6));
      write_reg(rat_pkg::CFG_WINDOW, (ph == 8) ? 32'hFFFFFFFF : $urandom_range(500, 5000));
      if (ph == 7) begin
        cyc_now = 32'hFFFF_F000;                       // cycle wrap region
        write_reg(rat_pkg::CFG_WINDOW, 32'd1);
      end
      random_phase(42, (ph < 5) ? 6 : 20);
      quiesce();
    end
    // a closing run with full-range cycles to exercise every input bit
    write_reg(rat_pkg::CFG_WINDOW, 32'hFFFFFFFF);
    for (int k = 0; k < 10; k++) begin
      add_act(16'($urandom), 0);
      cyc_now = $urandom;
    end
    quiesce();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
